FILE: rtl/mtcs_pkg.sv
// Shared types, codes and the helper function of the multithread core scheduler.
// Depends on nothing; the front end, back end and top level refer to it by scoped names.
package mtcs_pkg;

   typedef enum logic [1:0] {
      OP_WRITE_INSN = 2'd0,
      OP_WRITE_DATA = 2'd1,
      OP_STEP       = 2'd2,
      OP_READ       = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      OPC_NOP   = 3'd0,
      OPC_ADD   = 3'd1,
      OPC_SUB   = 3'd2,
      OPC_ADDI  = 3'd3,
      OPC_SUBI  = 3'd4,
      OPC_LOAD  = 3'd5,
      OPC_STORE = 3'd6,
      OPC_HALT  = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      EV_ACK     = 3'd0,
      EV_EXEC    = 3'd1,
      EV_SWITCH  = 3'd2,
      EV_IDLE    = 3'd3,
      EV_HALTED  = 3'd4
   } event_type;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THREAD_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_PEN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_LAT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STORE_LAT    = 3'd4;

   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 120;

   typedef struct packed {
      logic [2:0]  opc;
      logic [2:0]  dst;
      logic [2:0]  src1;
      logic [31:0] imm;
      logic        isimm;
   } insn_type;

   localparam int INSN_W = $bits(insn_type);

   typedef struct packed {
      op_type      op;
      logic [1:0]  tsel;
      logic [9:0]  loc;
      logic [2:0]  opc;
      logic [2:0]  dst;
      logic [2:0]  src1;
      logic [31:0] imm;
      logic        isimm;
      logic [31:0] word;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   // Reduce a small value modulo k by repeated compare and subtract.
   function automatic logic [4:0] fold_small(input logic [4:0] v, input logic [5:0] k);
      logic [5:0] r;
      r = {1'b0, v};
      for (int s = 0; s < 4; s++) begin
         if (r >= k) begin
            r = r - k;
         end
      end
      return r[4:0];
   endfunction

endpackage

FILE: rtl/mtcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mtcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/mtcs_mod.sv
// Iterative modulo unit: 32-bit value modulo a 17-bit divisor, 8 bits a cycle.
// Depends on nothing; result holds until the next start.
module mtcs_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [16:0] result
);

   logic [16:0] r_ff;
   logic [31:0] q_ff;
   logic [1:0]  cnt_ff;
   logic        act_ff;
   logic        done_ff;
   logic [16:0] r_step;
   logic [17:0] t;

   always_comb begin
      r_step = r_ff;
      t = '0;
      for (int k = 0; k < 8; k++) begin
         t = {r_step, q_ff[31-k]};
         if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
         end
         r_step = t[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            r_ff   <= '0;
            q_ff   <= dividend;
            cnt_ff <= '0;
            act_ff <= 1'b1;
         end else if (act_ff) begin
            r_ff   <= r_step;
            q_ff   <= {q_ff[23:0], 8'd0};
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               act_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

FILE: rtl/mtcs_front.sv
// Front end: accepts requests, classifies them into commands, queues two deep.
// Depends on mtcs_pkg.
module mtcs_front #(
   parameter int MAX_THREADS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mtcs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [1:0]                          req_tuser,
   input  logic                                hold_off,
   input  logic                                pop,
   output mtcs_pkg::queue_head_type            head
);

   mtcs_pkg::cmd_type ent_ff [2];
   logic [1:0]        cnt_ff;
   logic              rd_ff;
   logic              wr_ff;
   mtcs_pkg::cmd_type cmd;
   logic [4:0]        tsel_w;
   logic              push;

   // Classify: split the fields, wrap the thread select into range.
   always_comb begin
      tsel_w     = mtcs_pkg::fold_small({3'd0, req_tdata[1:0]}, 6'(MAX_THREADS));
      cmd.op     = mtcs_pkg::op_type'(req_tuser);
      cmd.tsel   = tsel_w[1:0];
      cmd.loc    = req_tdata[11:2];
      cmd.opc    = req_tdata[14:12];
      cmd.dst    = req_tdata[17:15];
      cmd.src1   = req_tdata[20:18];
      cmd.imm    = req_tdata[52:21];
      cmd.isimm  = req_tdata[53];
      cmd.word   = req_tdata[85:54];
   end

   assign req_tready = (cnt_ff != 2'd2) && !hold_off;
   assign push       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         if (push) begin
            ent_ff[wr_ff] <= cmd;
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.cmd   = ent_ff[rd_ff];

endmodule

FILE: rtl/mtcs_back.sv
// Back end: sequencer that carries out queued commands, thread state,
// memories and the result register. Depends on mtcs_pkg, mtcs_ram, mtcs_mod.
module mtcs_back #(
   parameter int MAX_THREADS = 4,
   parameter int NUM_REGS    = 8,
   parameter int IMEM_DEPTH  = 1024,
   parameter int DMEM_DEPTH  = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mtcs_pkg::queue_head_type        head,
   output logic                            pop,
   output logic                            clearing,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mtcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                      csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mtcs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [2:0]                      rsp_tuser
);

   localparam int TW       = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CW       = $clog2(MAX_THREADS + 1);
   localparam int RW       = $clog2(NUM_REGS);
   localparam int RF_DEPTH = MAX_THREADS * NUM_REGS;
   localparam int RFW      = (RF_DEPTH > 1) ? $clog2(RF_DEPTH) : 1;
   localparam int IW       = $clog2(IMEM_DEPTH);
   localparam int IM_DEPTH = MAX_THREADS * IMEM_DEPTH;
   localparam int IMW      = $clog2(IM_DEPTH);
   localparam int DW       = $clog2(DMEM_DEPTH);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_MOD_WAIT, S_WR_INSN, S_WR_DATA, S_RD_ADDR, S_RD_W1, S_RD_W2,
      S_STEP_CUR, S_SCAN, S_FETCH, S_FETCH_W1, S_FETCH_W2, S_REG_A, S_REG_B, S_REG_C,
      S_REG_D, S_REG_E, S_EXEC_OP, S_LD_ADDR, S_LD_W1, S_LD_W2, S_ST_WR, S_EXEC_END,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      SP_FIRST, SP_AFTER_EXEC, SP_AFTER_IDLE
   } purpose_type;

   state_type   state_ff;
   state_type   mod_next_ff;
   purpose_type purpose_ff;

   // configuration
   logic       mode_ff;
   logic [2:0] tcount_ff;
   logic [7:0] pen_ff;
   logic [7:0] lat_ld_ff;
   logic [7:0] lat_st_ff;

   // thread state
   logic [IW-1:0] pc_ff   [MAX_THREADS];
   logic [7:0]    busy_ff [MAX_THREADS];
   logic          run_ff  [MAX_THREADS];
   logic [TW-1:0] cur_ff;
   logic [TW-1:0] thr_ff;
   logic [39:0]   cyc_ff;
   logic [39:0]   inst_ff;

   logic [CW-1:0]  base_ff;
   logic [CW-1:0]  i_ff;
   logic [RFW-1:0] clr_ff;

   mtcs_pkg::cmd_type  cmd_ff;
   mtcs_pkg::insn_type ins_ff;
   logic [31:0]        s1_ff, s2_ff, dv_ff;
   mtcs_pkg::event_type rk_ff;
   logic [31:0]        rv_ff;

   logic                     rsp_valid_ff;
   mtcs_pkg::event_type      rsp_kind_ff;
   logic [mtcs_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   // memory and modulo unit controls
   logic              rf_we_ff;
   logic [RFW-1:0]    rf_waddr_ff, rf_raddr_ff;
   logic [31:0]       rf_wdata_ff, rf_rdata;
   logic              im_we_ff;
   logic [IMW-1:0]    im_waddr_ff, im_raddr_ff;
   mtcs_pkg::insn_type im_wdata_ff;
   logic [mtcs_pkg::INSN_W-1:0] im_rdata;
   logic              dm_we_ff;
   logic [DW-1:0]     dm_waddr_ff, dm_raddr_ff;
   logic [31:0]       dm_wdata_ff, dm_rdata;
   logic              mod_start_ff;
   logic [31:0]       mod_dvd_ff;
   logic [16:0]       mod_dvs_ff;
   logic              mod_done;
   logic [16:0]       mod_res;

   logic [CW-1:0] n_thr;
   logic [4:0]    tc5;
   logic          anyrun;
   logic [CW:0]   ssum;
   logic [TW-1:0] scan_t;
   logic          rdy_t;
   logic [31:0]   op2;
   logic [4:0]    src1_w, dst_w;

   mtcs_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf (
      .clock(clock), .we(rf_we_ff), .waddr(rf_waddr_ff), .wdata(rf_wdata_ff),
      .raddr(rf_raddr_ff), .rdata(rf_rdata)
   );

   mtcs_ram #(.WIDTH(mtcs_pkg::INSN_W), .DEPTH(IM_DEPTH)) u_imem (
      .clock(clock), .we(im_we_ff), .waddr(im_waddr_ff), .wdata(im_wdata_ff),
      .raddr(im_raddr_ff), .rdata(im_rdata)
   );

   mtcs_ram #(.WIDTH(32), .DEPTH(DMEM_DEPTH)) u_dmem (
      .clock(clock), .we(dm_we_ff), .waddr(dm_waddr_ff), .wdata(dm_wdata_ff),
      .raddr(dm_raddr_ff), .rdata(dm_rdata)
   );

   mtcs_mod u_mod (
      .clock(clock), .reset(reset), .start(mod_start_ff), .dividend(mod_dvd_ff),
      .divisor(mod_dvs_ff), .done(mod_done), .result(mod_res)
   );

   always_comb begin
      tc5 = {2'b00, tcount_ff};
      if (tc5 == 5'd0) begin
         n_thr = CW'(1);
      end else if (tc5 > 5'(MAX_THREADS)) begin
         n_thr = CW'(MAX_THREADS);
      end else begin
         n_thr = tc5[CW-1:0];
      end
      anyrun = 1'b0;
      for (int i = 0; i < MAX_THREADS; i++) begin
         anyrun = anyrun | (run_ff[i] && (CW'(i) < n_thr));
      end
      // scan position wraps once around the thread count
      ssum = {1'b0, base_ff} + {1'b0, i_ff};
      if (ssum >= {1'b0, n_thr}) begin
         ssum = ssum - {1'b0, n_thr};
      end
      scan_t = ssum[TW-1:0];
      rdy_t  = (busy_ff[scan_t] == 8'd0) && run_ff[scan_t];
      op2    = ins_ff.isimm ? ins_ff.imm : s2_ff;
      src1_w = mtcs_pkg::fold_small({2'b00, ins_ff.src1}, 6'(NUM_REGS));
      dst_w  = mtcs_pkg::fold_small({2'b00, ins_ff.dst}, 6'(NUM_REGS));
   end

   assign pop       = (state_ff == S_IDLE) && head.valid && (!rsp_valid_ff || rsp_tready);
   assign clearing  = (state_ff == S_CLEAR);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         mode_ff      <= 1'b0;
         tcount_ff    <= 3'd4;
         pen_ff       <= 8'd2;
         lat_ld_ff    <= 8'd4;
         lat_st_ff    <= 8'd1;
         for (int i = 0; i < MAX_THREADS; i++) begin
            pc_ff[i]   <= '0;
            busy_ff[i] <= '0;
            run_ff[i]  <= 1'b1;
         end
         cur_ff       <= '0;
         cyc_ff       <= '0;
         inst_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rf_we_ff     <= 1'b0;
         im_we_ff     <= 1'b0;
         dm_we_ff     <= 1'b0;
         mod_start_ff <= 1'b0;
      end else begin
         rf_we_ff     <= 1'b0;
         im_we_ff     <= 1'b0;
         dm_we_ff     <= 1'b0;
         mod_start_ff <= 1'b0;

         if (csr_valid) begin
            case (csr_index)
               mtcs_pkg::CSR_MODE:         mode_ff   <= csr_data[0];
               mtcs_pkg::CSR_THREAD_COUNT: tcount_ff <= csr_data[2:0];
               mtcs_pkg::CSR_SWITCH_PEN:   pen_ff    <= csr_data;
               mtcs_pkg::CSR_LOAD_LAT:     lat_ld_ff <= csr_data;
               mtcs_pkg::CSR_STORE_LAT:    lat_st_ff <= csr_data;
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_CLEAR: begin
               rf_we_ff    <= 1'b1;
               rf_waddr_ff <= clr_ff;
               rf_wdata_ff <= '0;
               if (clr_ff == RFW'(RF_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  clr_ff <= clr_ff + RFW'(1);
               end
            end
            S_IDLE: begin
               if (pop) begin
                  cmd_ff       <= head.cmd;
                  rv_ff        <= '0;
                  mod_start_ff <= 1'b1;
                  state_ff     <= S_MOD_WAIT;
                  case (head.cmd.op)
                     mtcs_pkg::OP_WRITE_INSN: begin
                        mod_dvd_ff  <= {22'd0, head.cmd.loc};
                        mod_dvs_ff  <= 17'(IMEM_DEPTH);
                        mod_next_ff <= S_WR_INSN;
                     end
                     mtcs_pkg::OP_WRITE_DATA: begin
                        mod_dvd_ff  <= {22'd0, head.cmd.loc};
                        mod_dvs_ff  <= 17'(DMEM_DEPTH);
                        mod_next_ff <= S_WR_DATA;
                     end
                     mtcs_pkg::OP_READ: begin
                        mod_dvd_ff  <= {22'd0, head.cmd.loc};
                        mod_dvs_ff  <= 17'(NUM_REGS);
                        mod_next_ff <= S_RD_ADDR;
                     end
                     default: begin
                        mod_dvd_ff  <= 32'(cur_ff);
                        mod_dvs_ff  <= 17'(n_thr);
                        mod_next_ff <= S_STEP_CUR;
                     end
                  endcase
               end
            end
            S_MOD_WAIT: begin
               if (mod_done) begin
                  state_ff <= mod_next_ff;
               end
            end
            S_WR_INSN: begin
               im_we_ff          <= 1'b1;
               im_waddr_ff       <= IMW'(int'(cmd_ff.tsel) * IMEM_DEPTH + int'(mod_res));
               im_wdata_ff.opc   <= cmd_ff.opc;
               im_wdata_ff.dst   <= cmd_ff.dst;
               im_wdata_ff.src1  <= cmd_ff.src1;
               im_wdata_ff.imm   <= cmd_ff.imm;
               im_wdata_ff.isimm <= cmd_ff.isimm;
               rk_ff    <= mtcs_pkg::EV_ACK;
               state_ff <= S_RESP;
            end
            S_WR_DATA: begin
               dm_we_ff    <= 1'b1;
               dm_waddr_ff <= mod_res[DW-1:0];
               dm_wdata_ff <= cmd_ff.word;
               rk_ff       <= mtcs_pkg::EV_ACK;
               state_ff    <= S_RESP;
            end
            S_RD_ADDR: begin
               rf_raddr_ff <= RFW'(int'(cmd_ff.tsel) * NUM_REGS + int'(mod_res));
               state_ff    <= S_RD_W1;
            end
            S_RD_W1: state_ff <= S_RD_W2;
            S_RD_W2: begin
               rv_ff    <= rf_rdata;
               rk_ff    <= mtcs_pkg::EV_ACK;
               state_ff <= S_RESP;
            end
            S_STEP_CUR: begin
               cur_ff <= mod_res[TW-1:0];
               if (!anyrun) begin
                  rk_ff    <= mtcs_pkg::EV_HALTED;
                  state_ff <= S_RESP;
               end else begin
                  purpose_ff <= SP_FIRST;
                  base_ff    <= CW'(mod_res[TW-1:0]);
                  i_ff       <= '0;
                  state_ff   <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (rdy_t) begin
                  case (purpose_ff)
                     SP_FIRST: begin
                        if (i_ff == '0 || mode_ff) begin
                           thr_ff   <= scan_t;
                           state_ff <= S_FETCH;
                        end else begin
                           // blocked switch: charge the penalty, move on
                           cyc_ff <= cyc_ff + 40'(pen_ff);
                           for (int i = 0; i < MAX_THREADS; i++) begin
                              if (CW'(i) < n_thr) begin
                                 busy_ff[i] <= (busy_ff[i] > pen_ff) ? busy_ff[i] - pen_ff : 8'd0;
                              end
                           end
                           cur_ff   <= scan_t;
                           rk_ff    <= mtcs_pkg::EV_SWITCH;
                           state_ff <= S_RESP;
                        end
                     end
                     SP_AFTER_EXEC: begin
                        cur_ff   <= scan_t;
                        rk_ff    <= mtcs_pkg::EV_EXEC;
                        state_ff <= S_RESP;
                     end
                     default: begin
                        cur_ff   <= scan_t;
                        rk_ff    <= mtcs_pkg::EV_IDLE;
                        state_ff <= S_RESP;
                     end
                  endcase
               end else if (i_ff == n_thr - CW'(1)) begin
                  case (purpose_ff)
                     SP_FIRST: begin
                        cyc_ff <= cyc_ff + 40'd1;
                        for (int i = 0; i < MAX_THREADS; i++) begin
                           if (CW'(i) < n_thr && busy_ff[i] != 8'd0) begin
                              busy_ff[i] <= busy_ff[i] - 8'd1;
                           end
                        end
                        if (mode_ff) begin
                           purpose_ff <= SP_AFTER_IDLE;
                           base_ff    <= CW'(cur_ff) + CW'(1);
                           i_ff       <= '0;
                        end else begin
                           rk_ff    <= mtcs_pkg::EV_IDLE;
                           state_ff <= S_RESP;
                        end
                     end
                     SP_AFTER_EXEC: begin
                        cur_ff   <= thr_ff;
                        rk_ff    <= mtcs_pkg::EV_EXEC;
                        state_ff <= S_RESP;
                     end
                     default: begin
                        rk_ff    <= mtcs_pkg::EV_IDLE;
                        state_ff <= S_RESP;
                     end
                  endcase
               end else begin
                  i_ff <= i_ff + CW'(1);
               end
            end
            S_FETCH: begin
               for (int i = 0; i < MAX_THREADS; i++) begin
                  if (CW'(i) < n_thr && busy_ff[i] != 8'd0) begin
                     busy_ff[i] <= busy_ff[i] - 8'd1;
                  end
               end
               im_raddr_ff <= IMW'(int'(thr_ff) * IMEM_DEPTH + int'(pc_ff[thr_ff]));
               state_ff    <= S_FETCH_W1;
            end
            S_FETCH_W1: state_ff <= S_FETCH_W2;
            S_FETCH_W2: begin
               ins_ff       <= im_rdata;
               mod_start_ff <= 1'b1;
               mod_dvd_ff   <= im_rdata[32:1];
               mod_dvs_ff   <= 17'(NUM_REGS);
               mod_next_ff  <= S_REG_A;
               state_ff     <= S_MOD_WAIT;
            end
            S_REG_A: begin
               rf_raddr_ff <= RFW'(int'(thr_ff) * NUM_REGS + int'(src1_w[RW-1:0]));
               state_ff    <= S_REG_B;
            end
            S_REG_B: begin
               rf_raddr_ff <= RFW'(int'(thr_ff) * NUM_REGS + int'(mod_res[RW-1:0]));
               state_ff    <= S_REG_C;
            end
            S_REG_C: begin
               s1_ff       <= rf_rdata;
               rf_raddr_ff <= RFW'(int'(thr_ff) * NUM_REGS + int'(dst_w[RW-1:0]));
               state_ff    <= S_REG_D;
            end
            S_REG_D: begin
               s2_ff    <= rf_rdata;
               state_ff <= S_REG_E;
            end
            S_REG_E: begin
               dv_ff    <= rf_rdata;
               state_ff <= S_EXEC_OP;
            end
            S_EXEC_OP: begin
               rf_waddr_ff <= RFW'(int'(thr_ff) * NUM_REGS + int'(dst_w[RW-1:0]));
               state_ff    <= S_EXEC_END;
               case (mtcs_pkg::opcode_type'(ins_ff.opc))
                  mtcs_pkg::OPC_ADD: begin
                     rf_we_ff    <= 1'b1;
                     rf_wdata_ff <= s1_ff + s2_ff;
                  end
                  mtcs_pkg::OPC_SUB: begin
                     rf_we_ff    <= 1'b1;
                     rf_wdata_ff <= s1_ff - s2_ff;
                  end
                  mtcs_pkg::OPC_ADDI: begin
                     rf_we_ff    <= 1'b1;
                     rf_wdata_ff <= s1_ff + ins_ff.imm;
                  end
                  mtcs_pkg::OPC_SUBI: begin
                     rf_we_ff    <= 1'b1;
                     rf_wdata_ff <= s1_ff - ins_ff.imm;
                  end
                  mtcs_pkg::OPC_LOAD: begin
                     busy_ff[thr_ff] <= lat_ld_ff;
                     mod_start_ff    <= 1'b1;
                     mod_dvd_ff      <= s1_ff + op2;
                     mod_dvs_ff      <= 17'(DMEM_DEPTH);
                     mod_next_ff     <= S_LD_ADDR;
                     state_ff        <= S_MOD_WAIT;
                  end
                  mtcs_pkg::OPC_STORE: begin
                     busy_ff[thr_ff] <= lat_st_ff;
                     mod_start_ff    <= 1'b1;
                     mod_dvd_ff      <= dv_ff + op2;
                     mod_dvs_ff      <= 17'(DMEM_DEPTH);
                     mod_next_ff     <= S_ST_WR;
                     state_ff        <= S_MOD_WAIT;
                  end
                  mtcs_pkg::OPC_HALT: run_ff[thr_ff] <= 1'b0;
                  default: ;
               endcase
            end
            S_LD_ADDR: begin
               dm_raddr_ff <= mod_res[DW-1:0];
               state_ff    <= S_LD_W1;
            end
            S_LD_W1: state_ff <= S_LD_W2;
            S_LD_W2: begin
               rf_we_ff    <= 1'b1;
               rf_wdata_ff <= dm_rdata;
               state_ff    <= S_EXEC_END;
            end
            S_ST_WR: begin
               dm_we_ff    <= 1'b1;
               dm_waddr_ff <= mod_res[DW-1:0];
               dm_wdata_ff <= s1_ff;
               state_ff    <= S_EXEC_END;
            end
            S_EXEC_END: begin
               pc_ff[thr_ff] <= (pc_ff[thr_ff] == IW'(IMEM_DEPTH - 1)) ? '0
                                                                       : pc_ff[thr_ff] + IW'(1);
               cyc_ff  <= cyc_ff + 40'd1;
               inst_ff <= inst_ff + 40'd1;
               if (mode_ff) begin
                  purpose_ff <= SP_AFTER_EXEC;
                  base_ff    <= CW'(thr_ff) + CW'(1);
                  i_ff       <= '0;
                  state_ff   <= S_SCAN;
               end else begin
                  rk_ff    <= mtcs_pkg::EV_EXEC;
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               rsp_kind_ff  <= rk_ff;
               rsp_data_ff  <= {6'd0, inst_ff, cyc_ff, rv_ff, 2'(cur_ff)};
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == S_IDLE) else $error("command taken outside idle");
   a_resp_set: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP |=> rsp_valid_ff) else $error("result not posted");
   a_mod_wait: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == S_MOD_WAIT) else $error("modulo result unclaimed");
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !head.valid) else $error("request queued during clear");

endmodule

FILE: rtl/multithread_core_scheduler_unit.sv
// Top level of the multithread core scheduler: front end, back end, ports.
// Depends on mtcs_pkg, mtcs_front, mtcs_back (and through it mtcs_ram, mtcs_mod).

// A request is one of: instruction write, data write, scheduling step or register
// read, and every request returns exactly one response. Requests enter a two-deep
// queue and are carried out one at a time by a sequencer that shares a single
// iterative modulo unit and one-write, one-read register file, instruction and
// data RAMs. A step scans up to MAX_THREADS threads for a ready one and then only
// switches or idles, or executes an instruction (a load or store adds a modulo
// reduction and a data RAM access, and fine-grained mode adds another scan).
// After reset a clearing pass zeroes all MAX_THREADS*NUM_REGS register-file
// entries, during which req_tready stays low; configuration writes are taken at
// any time but must only be issued while the block is idle.
module multithread_core_scheduler_unit #(
   parameter int MAX_THREADS = 4,
   parameter int NUM_REGS    = 8,
   parameter int IMEM_DEPTH  = 1024,
   parameter int DMEM_DEPTH  = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // thread_sel, location, opcode_in, dest_reg, first_src, second_or_imm,
   // uses_imm, word_in; upper two bits zero
   input  logic [mtcs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // op
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // thread_now, reg_value, cycle_total, inst_total; upper six bits zero
   output logic [mtcs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // event_kind
   output logic [2:0]                       rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mtcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                       csr_data
);

   mtcs_pkg::queue_head_type head;
   logic pop;
   logic clearing;

   // Accept and classify; hold off while the register files are cleared.
   mtcs_front #(.MAX_THREADS(MAX_THREADS)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .hold_off(clearing), .pop(pop), .head(head)
   );

   // Execute commands, drive the response register.
   mtcs_back #(
      .MAX_THREADS(MAX_THREADS), .NUM_REGS(NUM_REGS),
      .IMEM_DEPTH(IMEM_DEPTH), .DMEM_DEPTH(DMEM_DEPTH)
   ) u_back (
      .clock(clock), .reset(reset),
      .head(head), .pop(pop), .clearing(clearing),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

endmodule
